// ===== sv/assert_macros.svh =====
// Assertion helper macros for the integer ALU block.
// Needs clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold while out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/svalu_pkg.sv =====
// Package for the stack machine integer ALU: opcodes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package svalu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W         = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_AND  = 5'd7,
    OP_SHL  = 5'd8,
    OP_LAND = 5'd9,
    OP_LOR  = 5'd10,
    OP_LXOR = 5'd11,
    OP_LNOT = 5'd12,
    OP_LT   = 5'd13,
    OP_GT   = 5'd14,
    OP_EQ   = 5'd15,
    OP_LE   = 5'd16,
    OP_GE   = 5'd17,
    OP_ABS  = 5'd18,
    OP_SGN  = 5'd19,
    OP_INC  = 5'd20,
    OP_DEC  = 5'd21
  } op_t;

endpackage

// ===== sv/svalu_dly.sv =====
// Delay line with a reset valid bit per stage and unreset payload.
// No dependencies.
`timescale 1ns / 1ps

module svalu_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_vld,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [DEPTH-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    data_r[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      data_r[i] <= data_r[i-1];
    end
  end

  assign out_vld  = vld_r[DEPTH-1];
  assign out_data = data_r[DEPTH-1];

endmodule

// ===== sv/svalu_fast.sv =====
// Combinational ops: add/sub with overflow, bitwise, shift, logic, compares, unary.
// Depends on svalu_pkg.
`timescale 1ns / 1ps

module svalu_fast #(
  parameter int W = svalu_pkg::DATA_WIDTH_DEF
) (
  input  logic [svalu_pkg::FUNC_W-1:0] func,
  input  logic signed [W-1:0]          a,
  input  logic signed [W-1:0]          b,
  output logic [W-1:0]                 value,
  output logic                         ovf
);

  localparam int SW = $clog2(W);
  localparam logic [W-1:0] W_VAL = W'(W);
  localparam logic [W-1:0] ONE   = W'(1);

  logic [W-1:0] sum, dif, neg_b, amt;
  logic         ta, tb;

  assign sum   = a + b;
  assign dif   = a - b;
  assign neg_b = ~b + ONE;
  assign amt   = b[W-1] ? neg_b : b;
  assign ta    = (a != '0);
  assign tb    = (b != '0);

  always_comb begin
    value = '0;
    ovf   = 1'b0;
    unique case (func)
      svalu_pkg::OP_ADD: begin
        value = sum;
        ovf   = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
      end
      svalu_pkg::OP_SUB: begin
        value = dif;
        ovf   = (a[W-1] != b[W-1]) && (dif[W-1] != a[W-1]);
      end
      svalu_pkg::OP_OR:  value = a | b;
      svalu_pkg::OP_XOR: value = a ^ b;
      svalu_pkg::OP_AND: value = a & b;
      svalu_pkg::OP_SHL: begin
        if (b[W-1]) begin
          value = (amt >= W_VAL) ? {W{a[W-1]}} : W'(a >>> amt[SW-1:0]);
        end else if (tb) begin
          value = (amt >= W_VAL) ? '0 : W'(a << amt[SW-1:0]);
        end else begin
          value = a;
        end
      end
      svalu_pkg::OP_LAND: value = {{(W-1){1'b0}}, ta && tb};
      svalu_pkg::OP_LOR:  value = {{(W-1){1'b0}}, ta || tb};
      svalu_pkg::OP_LXOR: value = {{(W-1){1'b0}}, ta != tb};
      svalu_pkg::OP_LNOT: value = {{(W-1){1'b0}}, !tb};
      svalu_pkg::OP_LT:   value = {{(W-1){1'b0}}, a < b};
      svalu_pkg::OP_GT:   value = {{(W-1){1'b0}}, a > b};
      svalu_pkg::OP_EQ:   value = {{(W-1){1'b0}}, a == b};
      svalu_pkg::OP_LE:   value = {{(W-1){1'b0}}, a <= b};
      svalu_pkg::OP_GE:   value = {{(W-1){1'b0}}, a >= b};
      svalu_pkg::OP_ABS:  value = amt;
      svalu_pkg::OP_SGN:  value = b[W-1] ? {W{1'b1}} : (tb ? ONE : '0);
      svalu_pkg::OP_INC:  value = b + ONE;
      svalu_pkg::OP_DEC:  value = b - ONE;
      default: begin
        value = '0;
        ovf   = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/svalu_mul.sv =====
// Three-stage signed multiplier with overflow detect (two partial products).
// No dependencies.
`timescale 1ns / 1ps

module svalu_mul #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  a,
  input  logic signed [W-1:0]  b,
  output logic [W-1:0]         value,
  output logic                 ovf
);

  localparam int H  = W / 2;
  localparam int HU = W - H;
  localparam logic [2*W-1:0] SIGN_L = (2*W)'(1) << (W - 1);

  logic [W-1:0]      ma_r, mb_r;
  logic              neg1_r, neg2_r;
  logic [W+H-1:0]    pl_r;
  logic [W+HU-1:0]   ph_r;
  logic [W-1:0]      value_r;
  logic              ovf_r;
  logic [2*W-1:0]    prod, limit;
  logic [W-1:0]      ma_nxt, mb_nxt;

  assign ma_nxt = a[W-1] ? (~a + W'(1)) : a;
  assign mb_nxt = b[W-1] ? (~b + W'(1)) : b;

  // stage 1: magnitudes
  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    neg1_r <= a[W-1] ^ b[W-1];
  end

  // stage 2: partial products over low and high halves of b
  always_ff @(posedge clk) begin
    pl_r   <= ma_r * mb_r[H-1:0];
    ph_r   <= ma_r * mb_r[W-1:H];
    neg2_r <= neg1_r;
  end

  // stage 3: combine, sign, range check
  assign prod  = (2*W)'(pl_r) + ((2*W)'(ph_r) << H);
  assign limit = neg2_r ? SIGN_L : (SIGN_L - (2*W)'(1));

  always_ff @(posedge clk) begin
    value_r <= neg2_r ? (~prod[W-1:0] + W'(1)) : prod[W-1:0];
    ovf_r   <= prod > limit;
  end

  assign value = value_r;
  assign ovf   = ovf_r;

endmodule

// ===== sv/svalu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; quotient and remainder.
// No dependencies.
`timescale 1ns / 1ps

module svalu_div #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic signed [W-1:0]  a,
  input  logic signed [W-1:0]  b,
  output logic [W-1:0]         quo,
  output logic [W-1:0]         rem,
  output logic                 bz
);

  logic [W-1:0] rem_r  [W+1];
  logic [W-1:0] q_r    [W+1];
  logic [W-1:0] mb_r   [W+1];
  logic [W:0]   negq_r;
  logic [W:0]   negr_r;
  logic [W:0]   bz_r;
  logic [W-1:0] quo_r, remo_r;
  logic         bzo_r;

  // stage 0: magnitudes and signs
  always_ff @(posedge clk) begin
    rem_r[0]  <= '0;
    q_r[0]    <= a[W-1] ? (~a + W'(1)) : a;
    mb_r[0]   <= b[W-1] ? (~b + W'(1)) : b;
    negq_r[0] <= a[W-1] ^ b[W-1];
    negr_r[0] <= a[W-1];
    bz_r[0]   <= (b == '0);
  end

  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] sh, dif;
    logic       ge;

    assign sh  = {rem_r[i], q_r[i][W-1]};
    assign dif = sh - {1'b0, mb_r[i]};
    assign ge  = sh >= {1'b0, mb_r[i]};

    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? dif[W-1:0] : sh[W-1:0];
      q_r[i+1]    <= {q_r[i][W-2:0], ge};
      mb_r[i+1]   <= mb_r[i];
      negq_r[i+1] <= negq_r[i];
      negr_r[i+1] <= negr_r[i];
      bz_r[i+1]   <= bz_r[i];
    end
  end

  // sign fix; zero divisor forces both results to zero
  always_ff @(posedge clk) begin
    if (bz_r[W]) begin
      quo_r  <= '0;
      remo_r <= '0;
    end else begin
      quo_r  <= negq_r[W] ? (~q_r[W] + W'(1)) : q_r[W];
      remo_r <= negr_r[W] ? (~rem_r[W] + W'(1)) : rem_r[W];
    end
    bzo_r <= bz_r[W];
  end

  assign quo = quo_r;
  assign rem = remo_r;
  assign bz  = bzo_r;

endmodule

// ===== sv/stack_vm_integer_alu_top.sv =====
// Stack machine integer ALU, top level: input regs, fast/mul/div units, output regs.
// Depends on svalu_pkg, svalu_fast, svalu_mul, svalu_div, svalu_dly, assert_macros.svh.
// Throughput: one beat per cycle; busy is always low, every unit is fully pipelined.
// The depth is set by the divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) clears all valid bits; in-flight beats are dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stack_vm_integer_alu_top #(
  parameter int DATA_WIDTH = svalu_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [svalu_pkg::FUNC_W-1:0]  in_func,
  input  logic signed [DATA_WIDTH-1:0]  in_operand_a,
  input  logic signed [DATA_WIDTH-1:0]  in_operand_b,
  output logic                          out_valid,
  output logic signed [DATA_WIDTH-1:0]  out_value,
  output logic                          out_int_overflow,
  output logic                          out_div_by_zero
);

  localparam int W  = DATA_WIDTH;
  localparam int FW = svalu_pkg::FUNC_W;
  localparam int PW = FW + W + 1;   // func, value, overflow
  localparam int MUL_LAT = 3;

  // Input register stage
  logic                 s0_vld_r;
  logic [FW-1:0]        s0_func_r;
  logic signed [W-1:0]  s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_func_r <= in_func;
    s0_a_r    <= in_operand_a;
    s0_b_r    <= in_operand_b;
  end

  assign busy = 1'b0;

  // Combinational ops, computed from the input stage
  logic [W-1:0] fast_value;
  logic         fast_ovf;

  svalu_fast #(.W(W)) u_fast (
    .func  (s0_func_r),
    .a     (s0_a_r),
    .b     (s0_b_r),
    .value (fast_value),
    .ovf   (fast_ovf)
  );

  // Multiplier, latency matches the first delay line
  logic [W-1:0] mul_value;
  logic         mul_ovf;

  svalu_mul #(.W(W)) u_mul (
    .clk   (clk),
    .a     (s0_a_r),
    .b     (s0_b_r),
    .value (mul_value),
    .ovf   (mul_ovf)
  );

  // Divider, latency matches both delay lines together
  logic [W-1:0] div_quo, div_rem;
  logic         div_bz;

  svalu_div #(.W(W)) u_div (
    .clk (clk),
    .a   (s0_a_r),
    .b   (s0_b_r),
    .quo (div_quo),
    .rem (div_rem),
    .bz  (div_bz)
  );

  // First delay: fast result waits for the multiplier
  logic          d1_vld;
  logic [PW-1:0] d1_data;

  svalu_dly #(.WIDTH(PW), .DEPTH(MUL_LAT)) u_dly1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_data  ({s0_func_r, fast_value, fast_ovf}),
    .out_vld  (d1_vld),
    .out_data (d1_data)
  );

  // Merge multiplier result into the beat
  logic [FW-1:0] d1_func;
  logic [PW-1:0] m_data;

  assign d1_func = d1_data[PW-1 -: FW];
  assign m_data  = (d1_func == svalu_pkg::OP_MUL) ? {d1_func, mul_value, mul_ovf} : d1_data;

  // Second delay: wait for the divider
  logic          d2_vld;
  logic [PW-1:0] d2_data;

  svalu_dly #(.WIDTH(PW), .DEPTH(W - 1)) u_dly2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d1_vld),
    .in_data  (m_data),
    .out_vld  (d2_vld),
    .out_data (d2_data)
  );

  // Final select and output register
  logic [FW-1:0] d2_func;
  logic [W-1:0]  value_nxt;
  logic          ovf_nxt, dz_nxt;

  assign d2_func = d2_data[PW-1 -: FW];

  always_comb begin
    value_nxt = d2_data[W:1];
    ovf_nxt   = d2_data[0];
    dz_nxt    = 1'b0;
    if (d2_func == svalu_pkg::OP_DIV) begin
      value_nxt = div_quo;
      ovf_nxt   = 1'b0;
      dz_nxt    = div_bz;
    end else if (d2_func == svalu_pkg::OP_MOD) begin
      value_nxt = div_rem;
      ovf_nxt   = 1'b0;
    end
  end

  logic          out_vld_r;
  logic [W-1:0]  out_value_r;
  logic          out_ovf_r, out_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= value_nxt;
    out_ovf_r   <= ovf_nxt;
    out_dz_r    <= dz_nxt;
  end

  assign out_valid        = out_vld_r;
  assign out_value        = out_value_r;
  assign out_int_overflow = out_vld_r & out_ovf_r;
  assign out_div_by_zero  = out_vld_r & out_dz_r;

  // Checks
  `ASSERT_CLK(a_dz_zero, out_div_by_zero |-> (out_valid && out_value == '0), "div by zero with nonzero value")
  `ASSERT_NEVER(a_flags_excl, out_int_overflow && out_div_by_zero, "overflow and div by zero together")
  `ASSERT_CLK(a_rst_quiet, $past(!rst_n) |-> !out_valid, "result strobe right after reset")

endmodule

// ===== sim/svalu_checker.sv =====
// Result checker for the stack machine integer ALU: predicts each beat and compares.
// Depends on svalu_pkg; watches the command and result ports of the top level.
`timescale 1ns / 1ps

module svalu_checker #(
  parameter int DW = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [svalu_pkg::FUNC_W-1:0] in_func,
  input  logic signed [DW-1:0]         in_operand_a,
  input  logic signed [DW-1:0]         in_operand_b,
  input  logic                         out_valid,
  input  logic signed [DW-1:0]         out_value,
  input  logic                         out_int_overflow,
  input  logic                         out_div_by_zero,
  output int                           fail_cnt,
  output int                           pending_cnt,
  output int                           result_cnt
);
  import svalu_pkg::*;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          ovf;
    logic          dz;
  } alu_res_t;

  alu_res_t alu_expected_q[$];

  function automatic alu_res_t alu_predict(logic [4:0] fn, logic [DW-1:0] a,
                                           logic [DW-1:0] b);
    alu_res_t r;
    logic signed [2*DW-1:0] wide;
    logic signed [DW-1:0] sa, sb;
    logic [DW-1:0] ma, mb;
    longint amt;
    sa = a;
    sb = b;
    ma = a[DW-1] ? -a : a;
    mb = b[DW-1] ? -b : b;
    r = '0;
    case (op_t'(fn))
      OP_ADD: begin
        wide = (2*DW)'(sa) + (2*DW)'(sb);
        r.value = wide[DW-1:0];
        r.ovf = (wide != (2*DW)'(signed'(wide[DW-1:0])));
      end
      OP_SUB: begin
        wide = (2*DW)'(sa) - (2*DW)'(sb);
        r.value = wide[DW-1:0];
        r.ovf = (wide != (2*DW)'(signed'(wide[DW-1:0])));
      end
      OP_MUL: begin
        wide = (2*DW)'(sa) * (2*DW)'(sb);
        r.value = wide[DW-1:0];
        r.ovf = (wide != (2*DW)'(signed'(wide[DW-1:0])));
      end
      OP_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else begin
          r.value = ma / mb;
          if (a[DW-1] != b[DW-1]) r.value = -r.value;
        end
      end
      OP_MOD: begin
        if (b != 0) begin
          r.value = ma % mb;
          if (a[DW-1]) r.value = -r.value;
        end
      end
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_AND: r.value = a & b;
      OP_SHL: begin
        amt = mb;
        if (b[DW-1] && mb == 0) amt = longint'(1) << (DW - 1); // most negative
        if (sb > 0) r.value = (amt >= DW) ? '0 : a << amt;
        else if (sb < 0) begin
          // kept apart from a conditional so the shift stays arithmetic
          if (amt >= DW) r.value = {DW{a[DW-1]}};
          else r.value = sa >>> amt;
        end
        else r.value = a;
      end
      OP_LAND: r.value = DW'((a != 0) && (b != 0));
      OP_LOR:  r.value = DW'((a != 0) || (b != 0));
      OP_LXOR: r.value = DW'((a != 0) != (b != 0));
      OP_LNOT: r.value = DW'(b == 0);
      OP_LT:   r.value = DW'(sa < sb);
      OP_GT:   r.value = DW'(sa > sb);
      OP_EQ:   r.value = DW'(sa == sb);
      OP_LE:   r.value = DW'(sa <= sb);
      OP_GE:   r.value = DW'(sa >= sb);
      OP_ABS:  r.value = mb;
      OP_SGN:  r.value = (sb > 0) ? DW'(1) : ((sb < 0) ? '1 : '0);
      OP_INC:  r.value = b + 1'b1;
      OP_DEC:  r.value = b - 1'b1;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_cnt = alu_expected_q.size();

  always @(posedge clk) begin
    alu_res_t exp_r;
    if (!rst_n) begin
      fail_cnt   <= 0;
      result_cnt <= 0;
      alu_expected_q.delete();
    end else begin
      if (out_valid) begin
        result_cnt <= result_cnt + 1;
        if (alu_expected_q.size() == 0) begin
          $error("unexpected result beat, value %0d", out_value);
          fail_cnt <= fail_cnt + 1;
        end else begin
          exp_r = alu_expected_q.pop_front();
          if (exp_r.value !== out_value || exp_r.ovf !== out_int_overflow ||
              exp_r.dz !== out_div_by_zero) begin
            fail_cnt <= fail_cnt + 1;
            if (exp_r.value !== out_value)
              $error("value: expected %0d actual %0d", $signed(exp_r.value), out_value);
            if (exp_r.ovf !== out_int_overflow)
              $error("int_overflow: expected %0b actual %0b", exp_r.ovf, out_int_overflow);
            if (exp_r.dz !== out_div_by_zero)
              $error("div_by_zero: expected %0b actual %0b", exp_r.dz, out_div_by_zero);
          end
        end
      end
      if (start && !busy)
        alu_expected_q.push_back(alu_predict(in_func, in_operand_a, in_operand_b));
    end
  end
endmodule

// ===== sim/tb_stack_vm_integer_alu_top.sv =====
// Testbench top for the stack machine integer ALU: clock, reset, command stimulus, verdict.
// Depends on svalu_pkg, stack_vm_integer_alu_top and svalu_checker.
`timescale 1ns / 1ps

module tb_stack_vm_integer_alu_top;
  import svalu_pkg::*;

  localparam int DW         = DATA_WIDTH_DEF;
  localparam int N_RANDOM   = 1330;
  localparam int LATENCY    = DW + 3;
  localparam logic [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MIN_NEG = {1'b1, {(DW-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [DW-1:0] in_operand_a = '0;
  logic signed [DW-1:0] in_operand_b = '0;
  logic out_valid, out_int_overflow, out_div_by_zero;
  logic signed [DW-1:0] out_value;
  int fail_cnt, pending_cnt, result_cnt;
  int beats_sent = 0;

  always #6 clk = ~clk;

  stack_vm_integer_alu_top #(.DATA_WIDTH(DW)) i_dut (
    .clk, .rst_n, .start, .busy, .in_func, .in_operand_a, .in_operand_b,
    .out_valid, .out_value, .out_int_overflow, .out_div_by_zero
  );

  svalu_checker #(.DW(DW)) i_checker (
    .clk, .rst_n, .start, .busy, .in_func, .in_operand_a, .in_operand_b,
    .out_valid, .out_value, .out_int_overflow, .out_div_by_zero,
    .fail_cnt, .pending_cnt, .result_cnt
  );

  // Present one command and hold it until the block takes it.
  // start stays high across back-to-back beats; lowered by idle_cycles or before a drain.
  task automatic send_beat(logic [4:0] fn, logic [DW-1:0] a, logic [DW-1:0] b);
    start        <= 1'b1;
    in_func      <= fn;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Operand picker biased toward corners; the rest is uniform noise.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_NEG;
      1: return MAX_POS;
      2: return DW'($signed($urandom_range(0, 6)) - 3);
      3: return DW'($urandom_range(0, 80)) - DW'(40);  // shift amounts near width
      4: return DW'($urandom_range(0, 65535));
      5: return {DW{1'b0}} - DW'($urandom_range(1, 65535));
      default: return DW'($urandom);
    endcase
  endfunction

  // Random func: mostly legal opcodes, now and then an unused code.
  function automatic logic [4:0] pick_func();
    if ($urandom_range(0, 19) == 0) return 5'($urandom_range(22, 31));
    return 5'($urandom_range(OP_ADD, OP_DEC));
  endfunction

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: overflow edges, zero divisor, min / -1, shift limits,
    // abs of min, wrap on inc/dec, unused opcode.
    send_beat(OP_ADD, MAX_POS, 1);
    send_beat(OP_ADD, MIN_NEG, '1);
    send_beat(OP_SUB, MIN_NEG, 1);
    send_beat(OP_SUB, 0, MIN_NEG);
    send_beat(OP_MUL, MIN_NEG, '1);
    send_beat(OP_MUL, 65536, 32768);
    send_beat(OP_MUL, -65536, 32768);
    send_beat(OP_DIV, 7, 0);
    send_beat(OP_DIV, MIN_NEG, '1);
    send_beat(OP_DIV, -7, 2);
    send_beat(OP_MOD, 7, 0);
    send_beat(OP_MOD, -7, 2);
    send_beat(OP_MOD, MIN_NEG, '1);
    send_beat(OP_SHL, 1, 31);
    send_beat(OP_SHL, 1, 32);
    send_beat(OP_SHL, MIN_NEG, -32);
    send_beat(OP_SHL, MIN_NEG, MIN_NEG);
    send_beat(OP_SHL, 5, 0);
    send_beat(OP_ABS, 0, MIN_NEG);
    send_beat(OP_INC, 0, MAX_POS);
    send_beat(OP_DEC, 0, MIN_NEG);
    send_beat(OP_SGN, 0, MIN_NEG);
    send_beat(OP_LNOT, 0, 0);
    send_beat(5'd31, '1, '1);
    for (int f = OP_OR; f <= OP_GE; f++) send_beat(5'(f), pick_operand(), pick_operand());

    // Drain once before random traffic so the pipeline starts empty.
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);

    // Random bursts with random gaps, including long runs with no gap.
    while (beats_sent < N_RANDOM + 40) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_beat(pick_func(), pick_operand(), pick_operand());
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      if ($urandom_range(0, 60) == 0) begin
        start <= 1'b0;
        while (pending_cnt != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);

    $display("Sent %0d command beats over all opcodes, corners and unused codes;",
             beats_sent);
    $display("checked %0d result beats with random gaps and drains.", result_cnt);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog, sized far beyond the slowest legal run.
  initial begin
    #(12 * 200000);
    $display("FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/svalu_pkg.sv
sv/svalu_dly.sv
sv/svalu_fast.sv
sv/svalu_mul.sv
sv/svalu_div.sv
sv/stack_vm_integer_alu_top.sv
sim/svalu_checker.sv
sim/tb_stack_vm_integer_alu_top.sv
